// ===== sv/ica_pkg.sv =====
`default_nettype none
package ica_pkg;

  localparam int NUM_CHANNELS    = 16;
  localparam int NUM_INSTRUMENTS = 128;
  localparam int COUNT_WIDTH     = 16;

  localparam int CH_W   = $clog2(NUM_CHANNELS);
  localparam int MAP_AW = $clog2(NUM_INSTRUMENTS);
  localparam int INS_W  = 7;
  localparam int OUT_CH_W = 4;

  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [1:0]             opcode_t;
  typedef logic [1:0]             status_t;

  localparam opcode_t OP_USE  = 2'd0;
  localparam opcode_t OP_REL  = 2'd1;
  localparam opcode_t OP_STOP = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NEW   = 2'd1;
  localparam status_t ST_FREED = 2'd2;
  localparam status_t ST_FAIL  = 2'd3;

  // write port of the instrument map RAM
  typedef struct packed {
    logic                en;
    logic [MAP_AW-1:0]   addr;
    chan_t               data;
  } map_wr_t;

endpackage
`default_nettype wire

// ===== sv/ica_map_ram.sv =====
`default_nettype none
module ica_map_ram (
  input  wire                   clk,
  input  wire                   rd_en,
  input  wire [ica_pkg::MAP_AW-1:0] rd_addr,
  output ica_pkg::chan_t        rd_data,
  input  wire ica_pkg::map_wr_t wr
);
  import ica_pkg::*;

  chan_t mem [NUM_INSTRUMENTS];
  chan_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/instrument_channel_allocator.sv =====
`default_nettype none
// A result beat is loaded in S_LOOK after its input beat is accepted in S_IDLE,
// once the output is free. One request at a time: map RAM read, then update and
// answer. A stalled output holds the request in the update cycle until the beat
// drains. Reset (rst_n low, synchronous) clears all mappings and channels at
// once via valid flops; no clearing pass. Stop-all does the same in one beat.
module instrument_channel_allocator (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // [1:0] opcode, [8:2] instrument, [15:9] zero
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [3:0] channel, [5:4] status, [7:6] zero
);
  import ica_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;
  localparam logic [INS_W:0] NUM_INS_L = (INS_W+1)'(NUM_INSTRUMENTS);

  logic                    state_r, state_nxt;
  opcode_t                 op_r;
  logic [INS_W-1:0]        ins_r;
  logic [NUM_INSTRUMENTS-1:0] map_vld_r;
  logic [NUM_CHANNELS-1:0] own_vld_r;
  count_t                  cnt_r [NUM_CHANNELS];
  logic                    out_tvalid_r;
  logic [7:0]              out_tdata_r;

  logic     acc, out_free, ld;
  chan_t    map_rd;
  map_wr_t  map_wr;
  logic     ins_ok, mapv;
  count_t   cnt, cnt_dec;
  chan_t    free_ch;
  logic     free_found;
  chan_t    res_chan;
  status_t  res_status;
  logic     own_set, own_clr, mvld_set, mvld_clr, cnt_we, stop_all;
  chan_t    upd_ch;
  count_t   cnt_wd;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign ld        = (state_r == S_LOOK) && out_free;

  ica_map_ram u_map (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (in_tdata[2 +: MAP_AW]),
    .rd_data (map_rd),
    .wr      (map_wr)
  );

  // lowest free channel
  always_comb begin
    free_ch    = '0;
    free_found = 1'b0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (!own_vld_r[c]) begin
        free_ch    = CH_W'(c);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    ins_ok     = {1'b0, ins_r} < NUM_INS_L;
    mapv       = map_vld_r[ins_r[MAP_AW-1:0]];
    cnt        = cnt_r[map_rd];
    cnt_dec    = (cnt != '0) ? cnt - 1'b1 : '0;
    res_chan   = '0;
    res_status = ST_FAIL;
    own_set    = 1'b0;
    own_clr    = 1'b0;
    mvld_set   = 1'b0;
    mvld_clr   = 1'b0;
    cnt_we     = 1'b0;
    stop_all   = 1'b0;
    upd_ch     = map_rd;
    cnt_wd     = cnt;
    unique case (op_r)
      OP_STOP: begin
        stop_all   = 1'b1;
        res_status = ST_OK;
      end
      OP_USE: begin
        if (ins_ok && mapv) begin
          res_chan   = map_rd;
          res_status = ST_OK;
          cnt_we     = 1'b1;
          cnt_wd     = (cnt == '1) ? cnt : cnt + 1'b1;
        end else if (ins_ok && free_found) begin
          res_chan   = free_ch;
          res_status = ST_NEW;
          upd_ch     = free_ch;
          own_set    = 1'b1;
          mvld_set   = 1'b1;
          cnt_we     = 1'b1;
          cnt_wd     = count_t'(1);
        end
      end
      OP_REL: begin
        if (ins_ok && mapv) begin
          res_chan = map_rd;
          cnt_we   = 1'b1;
          cnt_wd   = cnt_dec;
          if (cnt_dec == '0) begin
            res_status = ST_FREED;
            own_clr    = 1'b1;
            mvld_clr   = 1'b1;
          end else begin
            res_status = ST_OK;
          end
        end
      end
      default: begin
        res_status = ST_FAIL;
      end
    endcase
  end

  assign map_wr.en   = ld && mvld_set;
  assign map_wr.addr = ins_r[MAP_AW-1:0];
  assign map_wr.data = free_ch;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = S_LOOK;
      S_LOOK:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_vld_r    <= '0;
      own_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld) begin
        out_tvalid_r <= 1'b1;
        if (stop_all) begin
          map_vld_r <= '0;
          own_vld_r <= '0;
        end
        if (mvld_set) map_vld_r[ins_r[MAP_AW-1:0]] <= 1'b1;
        if (mvld_clr) map_vld_r[ins_r[MAP_AW-1:0]] <= 1'b0;
        if (own_set)  own_vld_r[upd_ch] <= 1'b1;
        if (own_clr)  own_vld_r[upd_ch] <= 1'b0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // counts of free channels are never read, so they carry no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= in_tdata[1:0];
      ins_r <= in_tdata[2 +: INS_W];
    end
    if (ld && cnt_we) begin
      cnt_r[upd_ch] <= cnt_wd;
    end
    if (ld) begin
      out_tdata_r <= {2'b00, res_status, OUT_CH_W'(res_chan)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in flight");

  a_rise_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_LOOK))
    else $error("result beat without a request");

  a_new_owns: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && res_status == ST_NEW) |=> own_vld_r[$past(res_chan)])
    else $error("new mapping left channel free");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && stop_all) |=> (own_vld_r == '0 && map_vld_r == '0))
    else $error("stop all left a mapping");

  a_new_was_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && res_status == ST_NEW) |-> !own_vld_r[res_chan])
    else $error("new mapping on an owned channel");
`endif

endmodule
`default_nettype wire
